### hw/rtl/assert_macros.svh
// Assertion helpers used by the engine core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

### hw/rtl/sm3_pkg.sv
package sm3_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       end_of_message;
  } sm3_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sm3_out_t;

  localparam logic [31:0] T_LOW  = 32'h79CC4519;
  localparam logic [31:0] T_HIGH = 32'h7A879D8A;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam logic [31:0] IV [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  // Buffer write sources.
  typedef enum logic [1:0] {
    WSRC_MSG  = 2'd0,
    WSRC_PAD  = 2'd1,
    WSRC_ZERO = 2'd2,
    WSRC_LEN  = 2'd3
  } wsrc_t;

  typedef struct packed {
    logic       buf_we;
    logic [5:0] buf_addr;
    wsrc_t      buf_src;
    logic [7:0] msg_byte;
    logic       cnt_inc;
    logic       cnt_clr;
    logic       load_w;
    logic       round;
    logic       finish;
    logic       chain_init;
  } sm3_cmd_t;

  typedef struct packed {
    logic [60:0] byte_count;
    logic [5:0]  step;
  } sm3_sts_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

### hw/rtl/sm3_hash_engine_core.sv
// SM3 hash engine: at most one message byte per transaction, eight digest words out.
// A byte that does not fill a block is taken while idle; the byte that fills
// it is followed by the load, settle, round and finalize states, and no new
// byte is taken until they are through.
// End of message writes padding (and a length block if needed), then the eight digest words.
// rst_n is synchronous and active low; it loads the initial value, clears count.
`include "assert_macros.svh"
module sm3_hash_engine_core
  import sm3_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sm3_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output sm3_out_t out_data
);
  sm3_cmd_t    cmd;
  sm3_sts_t    sts;
  logic [31:0] chain [8];
  logic [2:0]  idx;

  sm3_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_idx  (idx),
    .cmd      (cmd),
    .sts      (sts)
  );

  sm3_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .chain_out(chain)
  );

  assign out_data.digest_word = chain[idx];
  assign out_data.word_index  = idx;
  assign out_data.last_word   = (idx == 3'd7);

  `ASSERT_NEVER(a_no_in_while_out, clk, rst_n, in_ready && out_valid)
  `ASSERT_IMPL(a_last_ends, clk, rst_n,
    (out_valid && out_ready && out_data.last_word) |=> in_ready)
  `ASSERT_NEVER(a_round_and_load, clk, rst_n, cmd.round && cmd.load_w)
endmodule

### hw/rtl/sm3_ram.sv
module sm3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/sm3_dp.sv
module sm3_dp
  import sm3_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  sm3_cmd_t    cmd,
  output sm3_sts_t    sts,
  output logic [31:0] chain_out [8]
);
  logic [60:0] cnt_r, cnt_nxt;
  logic [31:0] v_r [8];
  logic [31:0] a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [31:0] w_r [16];
  logic [5:0]  j_r;
  logic [7:0]  wdata;
  logic [63:0] bits;
  logic [1:0]  ld_r;
  logic [5:0]  raddr;
  logic [7:0]  rdata;
  logic [3:0]  lw_r;
  logic        lv_r;

  // Bit length: byte count times eight, modulo 2^64.
  assign bits = {cnt_r, 3'b000};

  always_comb begin
    unique case (cmd.buf_src)
      WSRC_MSG:  wdata = cmd.msg_byte;
      WSRC_PAD:  wdata = PAD_BYTE;
      WSRC_ZERO: wdata = 8'h00;
      WSRC_LEN:  wdata = bits[8*(7-cmd.buf_addr[2:0]) +: 8];
      default:   wdata = 8'h00;
    endcase
  end

  // Buffer is read sequentially during load; the step counter is the address.
  assign raddr = j_r;

  sm3_ram #(.WIDTH(8), .DEPTH(64)) u_buf (
    .clk  (clk),
    .we   (cmd.buf_we),
    .waddr(cmd.buf_addr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign cnt_nxt = cmd.cnt_clr ? '0 : (cmd.cnt_inc ? cnt_r + 61'd1 : cnt_r);

  // Round logic with a 16-word sliding message schedule.
  logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, tj, wj, w1j, wnew;
  always_comb begin
    tj  = (j_r < 6'd16) ? T_LOW : T_HIGH;
    a12 = rotl(a_r, 5'd12);
    ss1 = rotl(a12 + e_r + rotl(tj, j_r[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (j_r < 6'd16) begin
      ff = a_r ^ b_r ^ c_r;
      gg = e_r ^ f_r ^ g_r;
    end else begin
      ff = (a_r & b_r) | (a_r & c_r) | (b_r & c_r);
      gg = (e_r & f_r) | (~e_r & g_r);
    end
    wj   = w_r[0];
    w1j  = w_r[0] ^ w_r[4];
    tt1  = ff + d_r + ss2 + w1j;
    tt2  = gg + h_r + ss1 + wj;
    wnew = perm1(w_r[0] ^ w_r[7] ^ rotl(w_r[13], 5'd15)) ^ rotl(w_r[3], 5'd7) ^ w_r[10];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      j_r   <= '0;
      ld_r  <= '0;
      lv_r  <= 1'b0;
      lw_r  <= '0;
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= IV[i];
      end
    end else begin
      cnt_r <= cnt_nxt;
      lv_r  <= cmd.load_w;
      if (cmd.load_w) begin
        j_r <= j_r + 6'd1;
      end else if (cmd.round) begin
        j_r <= j_r + 6'd1;
      end else begin
        j_r <= '0;
      end
      // Registered read arrives in the cycle after its address.
      if (lv_r) begin
        w_r[lw_r] <= {w_r[lw_r][23:0], rdata};
        ld_r <= ld_r + 2'd1;
        if (ld_r == 2'd3) begin
          lw_r <= lw_r + 4'd1;
        end
      end
      if (cmd.load_w && j_r == 6'd0) begin
        a_r <= v_r[0]; b_r <= v_r[1]; c_r <= v_r[2]; d_r <= v_r[3];
        e_r <= v_r[4]; f_r <= v_r[5]; g_r <= v_r[6]; h_r <= v_r[7];
      end
      if (cmd.round) begin
        d_r <= c_r; c_r <= rotl(b_r, 5'd9); b_r <= a_r; a_r <= tt1;
        h_r <= g_r; g_r <= rotl(f_r, 5'd19); f_r <= e_r; e_r <= perm0(tt2);
        for (int i = 0; i < 15; i++) begin
          w_r[i] <= w_r[i+1];
        end
        w_r[15] <= wnew;
      end
      if (cmd.finish) begin
        v_r[0] <= v_r[0] ^ a_r; v_r[1] <= v_r[1] ^ b_r;
        v_r[2] <= v_r[2] ^ c_r; v_r[3] <= v_r[3] ^ d_r;
        v_r[4] <= v_r[4] ^ e_r; v_r[5] <= v_r[5] ^ f_r;
        v_r[6] <= v_r[6] ^ g_r; v_r[7] <= v_r[7] ^ h_r;
      end
      if (cmd.chain_init) begin
        for (int i = 0; i < 8; i++) begin
          v_r[i] <= IV[i];
        end
      end
    end
  end

  assign sts.byte_count = cnt_r;
  assign sts.step       = j_r;
  assign chain_out      = v_r;
endmodule

### hw/rtl/sm3_ctrl.sv
module sm3_ctrl
  import sm3_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  sm3_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_idx,
  output sm3_cmd_t    cmd,
  input  sm3_sts_t    sts
);
  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_LOAD   = 8'b00000010,
    S_SETTLE = 8'b00000100,
    S_ROUND  = 8'b00001000,
    S_FIN    = 8'b00010000,
    S_PAD    = 8'b00100000,
    S_LEN    = 8'b01000000,
    S_OUT    = 8'b10000000
  } state_t;

  state_t      state_r, state_nxt;
  logic        final_r, final_nxt;   // compression is part of padding
  logic        eom_r, eom_nxt;       // padding still owed after this compression
  logic        two_r, two_nxt;       // length block still owed
  logic [5:0]  pa_r, pa_nxt;
  logic [2:0]  oi_r, oi_nxt;
  logic [5:0]  pos;

  assign pos = sts.byte_count[5:0];

  always_comb begin
    state_nxt = state_r;
    final_nxt = final_r;
    eom_nxt   = eom_r;
    two_nxt   = two_r;
    pa_nxt    = pa_r;
    oi_nxt    = oi_r;
    cmd       = '0;
    cmd.buf_src  = WSRC_MSG;
    cmd.msg_byte = in_data.msg_byte;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.buf_we   = in_data.byte_valid;
          cmd.buf_addr = pos;
          cmd.cnt_inc  = in_data.byte_valid;
          eom_nxt      = in_data.end_of_message;
          final_nxt    = 1'b0;
          if (in_data.byte_valid && pos == 6'd63) begin
            state_nxt = S_LOAD;
          end else if (in_data.end_of_message) begin
            state_nxt = S_PAD;
            pa_nxt    = in_data.byte_valid ? pos + 6'd1 : pos;
          end
        end
      end
      S_LOAD: begin
        cmd.load_w = 1'b1;
        if (sts.step == 6'd63) begin
          state_nxt = S_SETTLE;
        end
      end
      S_SETTLE: begin
        // The last buffer byte lands in the schedule during this cycle.
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (sts.step == 6'd63) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        if (final_r && !two_r) begin
          state_nxt = S_OUT;
          oi_nxt    = '0;
        end else if (final_r) begin
          two_nxt   = 1'b0;
          state_nxt = S_LEN;
          pa_nxt    = '0;
        end else if (eom_r) begin
          state_nxt = S_PAD;
          pa_nxt    = '0;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_PAD: begin
        // Write 0x80 then zeros up to the end of the block; the length goes in bytes 56 to 63 if it fits.
        cmd.buf_we   = 1'b1;
        cmd.buf_addr = pa_r;
        cmd.buf_src  = (pa_r == pos) ? WSRC_PAD : WSRC_ZERO;
        pa_nxt       = pa_r + 6'd1;
        if (pa_r >= 6'd56 && pa_r != pos) begin
          if (pos < 6'd56) begin
            cmd.buf_src = WSRC_LEN;
          end
        end
        if (pa_r == 6'd63) begin
          final_nxt = 1'b1;
          two_nxt   = (pos >= 6'd56);
          state_nxt = S_LOAD;
        end
      end
      S_LEN: begin
        cmd.buf_we   = 1'b1;
        cmd.buf_addr = pa_r;
        cmd.buf_src  = (pa_r >= 6'd56) ? WSRC_LEN : WSRC_ZERO;
        pa_nxt       = pa_r + 6'd1;
        if (pa_r == 6'd63) begin
          state_nxt = S_LOAD;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          oi_nxt = oi_r + 3'd1;
          if (oi_r == 3'd7) begin
            cmd.chain_init = 1'b1;
            cmd.cnt_clr    = 1'b1;
            state_nxt      = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_idx = oi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      final_r <= 1'b0;
      eom_r   <= 1'b0;
      two_r   <= 1'b0;
      pa_r    <= '0;
      oi_r    <= '0;
    end else begin
      state_r <= state_nxt;
      final_r <= final_nxt;
      eom_r   <= eom_nxt;
      two_r   <= two_nxt;
      pa_r    <= pa_nxt;
      oi_r    <= oi_nxt;
    end
  end
endmodule

### sim/sm3_digest_checker.sv
module sm3_digest_checker
  import sm3_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  sm3_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  sm3_out_t out_data,
  output int       fail_count,
  output int       pending_words
);

  logic [31:0] chain [8];
  logic [7:0]  msg_block [64];
  logic [60:0] msg_len;
  sm3_out_t    digest_q [$];

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    int k;
    k = n % 32;
    if (k == 0) return x;
    return (x << k) | (x >> (32 - k));
  endfunction

  function automatic logic [31:0] p0f(input logic [31:0] x);
    return x ^ rol(x, 9) ^ rol(x, 17);
  endfunction

  function automatic logic [31:0] p1f(input logic [31:0] x);
    return x ^ rol(x, 15) ^ rol(x, 23);
  endfunction

  task automatic compress_block();
    logic [31:0] w [68];
    logic [31:0] v [8];
    logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, tj;
    for (int j = 0; j < 16; j++)
      w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
    for (int j = 16; j < 68; j++)
      w[j] = p1f(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int j = 0; j < 64; j++) begin
      tj = (j < 16) ? T_LOW : T_HIGH;
      a12 = rol(v[0], 12);
      ss1 = rol(a12 + v[4] + rol(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = v[0] ^ v[1] ^ v[2];
        gg = v[4] ^ v[5] ^ v[6];
      end else begin
        ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
        gg = (v[4] & v[5]) | (~v[4] & v[6]);
      end
      tt1 = ff + v[3] + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + v[7] + ss1 + w[j];
      v[3] = v[2]; v[2] = rol(v[1], 9); v[1] = v[0]; v[0] = tt1;
      v[7] = v[6]; v[6] = rol(v[5], 19); v[5] = v[4]; v[4] = p0f(tt2);
    end
    for (int i = 0; i < 8; i++) chain[i] ^= v[i];
  endtask

  task automatic absorb_item(input sm3_in_t it);
    int pos;
    logic [63:0] bits;
    sm3_out_t r;
    if (it.byte_valid) begin
      msg_block[msg_len[5:0]] = it.msg_byte;
      msg_len = msg_len + 1;
      if (msg_len[5:0] == 0) compress_block();
    end
    if (!it.end_of_message) return;
    pos = msg_len[5:0];
    bits = {msg_len, 3'b000};
    msg_block[pos] = PAD_BYTE;
    pos++;
    for (int i = pos; i < 64; i++) msg_block[i] = 8'h00;
    if (pos > 56) begin
      compress_block();
      for (int i = 0; i < 56; i++) msg_block[i] = 8'h00;
    end
    for (int k = 0; k < 8; k++) msg_block[56+k] = bits[63-8*k -: 8];
    compress_block();
    for (int k = 0; k < 8; k++) begin
      r.digest_word = chain[k];
      r.word_index = k[2:0];
      r.last_word = (k == 7);
      digest_q.push_back(r);
    end
    for (int i = 0; i < 8; i++) chain[i] = IV[i];
    msg_len = '0;
  endtask

  assign pending_words = digest_q.size();

  always @(posedge clk) begin
    sm3_out_t exp_w;
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) chain[i] <= IV[i];
      msg_len <= '0;
      fail_count <= 0;
      digest_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected digest word %h", out_data);
        end else begin
          exp_w = digest_q.pop_front();
          if (exp_w !== out_data) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected word %h idx %0d last %b, got %h idx %0d last %b",
                       exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                       out_data.digest_word, out_data.word_index, out_data.last_word);
          end
        end
      end
      // The expectation is queued after the compare, so same-edge ordering holds.
      if (in_valid && in_ready) absorb_item(in_data);
    end
  end

endmodule

### sim/sm3_hash_engine_core_tb.sv
module sm3_hash_engine_core_tb;
  import sm3_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  sm3_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  sm3_out_t out_data;
  int       fail_count;
  int       pending_words;
  int       idle_cycles = 0;
  bit       hold_off = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sm3_hash_engine_core dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data
  );

  sm3_digest_checker checker_i (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data, .fail_count, .pending_words
  );

  task automatic send_item(input logic [7:0] b, input logic bv, input logic eom);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(negedge clk);
    in_data <= '{msg_byte: b, byte_valid: bv, end_of_message: eom};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic send_message(input int len, input bit eom_with_byte);
    for (int i = 0; i < len; i++)
      send_item(8'($urandom_range(0, 255)), 1'b1, eom_with_byte && (i == len - 1));
    if (!eom_with_byte || len == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Receiver: random stalls, and one long hold-off while the sender keeps going.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // Directed: empty message, empty items, extreme bytes, padding boundaries.
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'hA5, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b1);
    send_message(55, 1'b1);
    send_message(56, 1'b1);
    send_message(64, 1'b0);
    // Long receiver hold-off with several short messages queued.
    fork
      begin
        hold_off = 1'b1;
        repeat (1500) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 4; i++)
          send_message($urandom_range(0, 3), 1'($urandom_range(0, 1)));
      end
    join
    // Random: mostly short messages, occasional empty items, a few longer ones.
    for (int m = 0; m < 3; m++) begin
      if ($urandom_range(0, 4) == 0)
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      if ($urandom_range(0, 9) == 0)
        send_message($urandom_range(57, 70), 1'($urandom_range(0, 1)));
      else send_message($urandom_range(0, 8), 1'($urandom_range(0, 1)));
    end
    while (pending_words != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
